// File: src/hps_pkg.sv
// Shared types, codes and constants of the host power supervisor.
package hps_pkg;

	// Configuration register layout.
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WD_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 2'd2;

	localparam logic [CFG_W-1:0] RST_FIRST_WD  = 16'd5000;
	localparam logic [CFG_W-1:0] RST_WD_PERIOD = 16'd2000;
	localparam logic [CFG_W-1:0] RST_OFF_DELAY = 16'd4000;

	// Field widths of one transaction.
	localparam int ELAPSED_W = 10;
	localparam int KEY_W     = 3;
	localparam int MSG_W     = 4;
	localparam int LED_W     = 3;
	localparam int RESP_W    = 3;
	localparam int SUP_W     = 2;

	// Key event codes.
	localparam logic [KEY_W-1:0] KEY_PRESSING   = 3'd1;
	localparam logic [KEY_W-1:0] KEY_SHORT      = 3'd2;
	localparam logic [KEY_W-1:0] KEY_SUPER_LONG = 3'd5;

	// Received message codes.
	localparam logic [MSG_W-1:0] MSG_NONE      = 4'd0;
	localparam logic [MSG_W-1:0] MSG_STATUS    = 4'd1;
	localparam logic [MSG_W-1:0] MSG_ANALOG    = 4'd2;
	localparam logic [MSG_W-1:0] MSG_POWEROFF  = 4'd3;
	localparam logic [MSG_W-1:0] MSG_VERSION   = 4'd4;
	localparam logic [MSG_W-1:0] MSG_BOOT      = 4'd5;
	localparam logic [MSG_W-1:0] MSG_SHUT_ACK  = 4'd6;
	localparam logic [MSG_W-1:0] MSG_READY_ACK = 4'd7;

	// LED mode codes.
	localparam logic [LED_W-1:0] LED_UNCHANGED = 3'd0;
	localparam logic [LED_W-1:0] LED_OFF       = 3'd1;
	localparam logic [LED_W-1:0] LED_ON        = 3'd2;
	localparam logic [LED_W-1:0] LED_BLINK_1000 = 3'd3;
	localparam logic [LED_W-1:0] LED_BLINK_250 = 3'd4;
	localparam logic [LED_W-1:0] LED_BLINK_150 = 3'd5;

	// Response codes.
	localparam logic [RESP_W-1:0] RESP_NONE     = 3'd0;
	localparam logic [RESP_W-1:0] RESP_STATUS   = 3'd1;
	localparam logic [RESP_W-1:0] RESP_ANALOG   = 3'd2;
	localparam logic [RESP_W-1:0] RESP_POWEROFF = 3'd3;
	localparam logic [RESP_W-1:0] RESP_VERSION  = 3'd4;

	// Supply action codes.
	localparam logic [SUP_W-1:0] SUP_NONE  = 2'd0;
	localparam logic [SUP_W-1:0] SUP_OFF   = 2'd1;
	localparam logic [SUP_W-1:0] SUP_CYCLE = 2'd2;

	// Host state.
	typedef enum logic [2:0] {
		ST_UNKNOWN = 3'd0,
		ST_STBY    = 3'd1,
		ST_START   = 3'd2,
		ST_RUN     = 3'd3,
		ST_SHUT    = 3'd4,
		ST_PWROFF  = 3'd5
	} host_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] first_wd;
		logic [CFG_W-1:0] wd_period;
		logic [CFG_W-1:0] off_delay;
	} cfg_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed;
		logic [KEY_W-1:0]     key;
		logic                 rx;
		logic [MSG_W-1:0]     msg;
	} item_t;

	typedef struct packed {
		host_state_t       host_state;
		logic [LED_W-1:0]  led_mode;
		logic              query;
		logic [RESP_W-1:0] resp;
		logic [SUP_W-1:0]  supply;
		logic              boot;
	} result_t;

endpackage

// File: src/host_power_supervisor_unit.sv
// Top level of the host power supervisor: input register, step logic, result register.
// Each transaction is one handler call of the supervisor. A call is taken into an input
// register, evaluated combinationally against the host state, timers and flags, and its
// result is held in an output register, which loads as the call leaves the input register
// and holds until the result is taken; one call is taken every clock while results are
// taken. The state updates as a call leaves the input register, so back-to-back calls
// see each other's effects in order. Timers are TIMER_WIDTH bits wide and saturate on
// load; there is no clearing pass after reset.
module host_power_supervisor_unit #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [hps_pkg::ELAPSED_W-1:0]  elapsed_ms,
	input  logic [hps_pkg::KEY_W-1:0]      key_event,
	input  logic                           rx_level,
	input  logic [hps_pkg::MSG_W-1:0]      rx_message,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [2:0]                     host_state,
	output logic [hps_pkg::LED_W-1:0]      led_mode,
	output logic                           send_ready_query,
	output logic [hps_pkg::RESP_W-1:0]     response_kind,
	output logic [hps_pkg::SUP_W-1:0]      supply_action,
	output logic                           enter_bootloader,
	input  logic                           cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hps_pkg::CFG_W-1:0]      cfg_wdata
);
	import hps_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb, res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	hps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hps_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_comb)
	);

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.elapsed <= elapsed_ms;
			item_s1.key     <= key_event;
			item_s1.rx      <= rx_level;
			item_s1.msg     <= rx_message;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign result_valid     = valid_s2;
	assign host_state       = res_s2.host_state;
	assign led_mode         = res_s2.led_mode;
	assign send_ready_query = res_s2.query;
	assign response_kind    = res_s2.resp;
	assign supply_action    = res_s2.supply;
	assign enter_bootloader = res_s2.boot;

	// A waiting call stays in the input register until it moves on.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped a waiting transaction");

	// Switching the supply off only happens on the way back to standby.
	a_off_to_stby: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.supply == SUP_OFF |-> res_s2.host_state == ST_STBY)
		else $error("supply switched off outside the return to standby");

	// A power cycle is requested only from standby.
	a_cycle_stby: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.supply == SUP_CYCLE
		|-> res_s2.host_state == ST_STBY || res_s2.host_state == ST_PWROFF)
		else $error("power cycle requested outside standby");

	// Ready queries and bootloader requests belong to a running host.
	a_query_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.query || res_s2.boot)
		|-> res_s2.host_state == ST_RUN || res_s2.host_state == ST_SHUT)
		else $error("host request issued while host not running");

endmodule

// File: src/hps_cfg.sv
// Configuration registers of the host power supervisor.
module hps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hps_pkg::CFG_W-1:0]      cfg_wdata,
	output hps_pkg::cfg_t                  cfg
);
	import hps_pkg::*;

	cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_wd  <= RST_FIRST_WD;
			cfg_q.wd_period <= RST_WD_PERIOD;
			cfg_q.off_delay <= RST_OFF_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_WD:  cfg_q.first_wd  <= cfg_wdata;
				CFG_WD_PERIOD: cfg_q.wd_period <= cfg_wdata;
				CFG_OFF_DELAY: cfg_q.off_delay <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/hps_core.sv
// Host state machine, timers and flags, evaluated once per transaction.
module hps_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  hps_pkg::item_t   item,
	input  hps_pkg::cfg_t    cfg,
	output hps_pkg::result_t result
);
	import hps_pkg::*;

	localparam int LW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [LW-1:0] TMAX = (LW'(1) << TIMER_WIDTH) - LW'(1);

	// Loads saturate at the largest value the timer holds.
	function automatic logic [TIMER_WIDTH-1:0] load_timer(input logic [CFG_W-1:0] v);
		logic [LW-1:0] ext;
		ext = LW'(v);
		return (ext > TMAX) ? TIMER_WIDTH'(TMAX) : TIMER_WIDTH'(ext);
	endfunction

	function automatic logic [TIMER_WIDTH-1:0] count_down(input logic [TIMER_WIDTH-1:0] t,
			input logic [ELAPSED_W-1:0] d);
		logic [TIMER_WIDTH-1:0] dx;
		dx = TIMER_WIDTH'(d);
		return (t > dx) ? (t - dx) : '0;
	endfunction

	host_state_t            state_q, state_d;
	logic                   pend_q, pend_d;
	logic                   ans_q, ans_d;
	logic [TIMER_WIDTH-1:0] wd_q, wd_d;
	logic [TIMER_WIDTH-1:0] dl_q, dl_d;
	logic [TIMER_WIDTH-1:0] wd_dec, dl_dec;

	assign wd_dec = count_down(wd_q, item.elapsed);
	assign dl_dec = count_down(dl_q, item.elapsed);

	// Next state, timers and flags.
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		ans_d   = ans_q;
		wd_d    = wd_dec;
		dl_d    = dl_dec;
		unique case (state_q)
			ST_UNKNOWN: begin
				if (item.rx) begin
					wd_d    = load_timer(cfg.first_wd);
					ans_d   = 1'b0;
					state_d = ST_RUN;
				end else begin
					state_d = ST_STBY;
				end
			end
			ST_RUN: begin
				if (wd_dec == '0) begin
					if (ans_q) begin
						wd_d  = load_timer(cfg.wd_period);
						ans_d = 1'b0;
					end else begin
						state_d = ST_SHUT;
					end
				end
				if (item.key == KEY_SUPER_LONG) begin
					pend_d = 1'b1;
				end
				if (item.msg == MSG_POWEROFF) begin
					pend_d  = 1'b1;
					state_d = ST_SHUT;
				end else if (item.msg == MSG_SHUT_ACK) begin
					state_d = ST_SHUT;
				end else if (item.msg == MSG_READY_ACK) begin
					ans_d = 1'b1;
				end
			end
			ST_SHUT: begin
				if (!item.rx) begin
					state_d = ST_STBY;
				end
			end
			ST_STBY: begin
				if (item.rx) begin
					state_d = ST_START;
				end else begin
					if (pend_q) begin
						dl_d    = load_timer(cfg.off_delay);
						state_d = ST_PWROFF;
					end
					// The blocking power cycle leaves the delay timer empty.
					if (item.key == KEY_SHORT) begin
						dl_d = '0;
					end
				end
			end
			ST_START: begin
				if (item.rx && dl_dec == '0 && item.msg != MSG_NONE) begin
					ans_d   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_PWROFF: begin
				if (dl_dec == '0) begin
					pend_d  = 1'b0;
					state_d = ST_STBY;
				end
			end
			default: ;
		endcase
	end

	// Result fields of the transaction.
	always_comb begin
		result            = '0;
		result.host_state = state_d;
		result.led_mode   = LED_UNCHANGED;
		result.query      = 1'b0;
		result.resp       = RESP_NONE;
		result.supply     = SUP_NONE;
		result.boot       = 1'b0;
		unique case (state_q)
			ST_UNKNOWN: begin
				result.query = item.rx;
			end
			ST_RUN: begin
				result.query    = (wd_dec == '0) && ans_q;
				result.led_mode = (item.key == KEY_PRESSING) ? LED_BLINK_1000 : LED_ON;
				unique case (item.msg)
					MSG_STATUS:   result.resp = RESP_STATUS;
					MSG_ANALOG:   result.resp = RESP_ANALOG;
					MSG_POWEROFF: result.resp = RESP_POWEROFF;
					MSG_VERSION:  result.resp = RESP_VERSION;
					MSG_BOOT:     result.boot = 1'b1;
					default: ;
				endcase
			end
			ST_SHUT: begin
				result.led_mode = LED_BLINK_250;
			end
			ST_STBY: begin
				result.led_mode = LED_OFF;
				if (!item.rx && item.key == KEY_SHORT) begin
					result.supply = SUP_CYCLE;
				end
			end
			ST_START: begin
				result.led_mode = LED_BLINK_150;
			end
			ST_PWROFF: begin
				if (dl_dec == '0) begin
					result.supply = SUP_OFF;
				end
			end
			default: ;
		endcase
	end

	// State registers move when a transaction leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_UNKNOWN;
			pend_q  <= 1'b0;
			ans_q   <= 1'b0;
			wd_q    <= '0;
			dl_q    <= '0;
		end else if (advance) begin
			state_q <= state_d;
			pend_q  <= pend_d;
			ans_q   <= ans_d;
			wd_q    <= wd_d;
			dl_q    <= dl_d;
		end
	end

endmodule

// File: sim/hps_call_checker.sv
// Checker for the host power supervisor: call predictor, expected-result queue and compare.
module hps_call_checker #(
	parameter int TIMER_W = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  logic [hps_pkg::ELAPSED_W-1:0] elapsed_ms,
	input  logic [hps_pkg::KEY_W-1:0]     key_event,
	input  logic                          rx_level,
	input  logic [hps_pkg::MSG_W-1:0]     rx_message,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [2:0]                    host_state,
	input  logic [hps_pkg::LED_W-1:0]     led_mode,
	input  logic                          send_ready_query,
	input  logic [hps_pkg::RESP_W-1:0]    response_kind,
	input  logic [hps_pkg::SUP_W-1:0]     supply_action,
	input  logic                          enter_bootloader,
	input  logic                          cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hps_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            errors,
	output int                            outstanding
);
	import hps_pkg::*;

	localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_W) - 64'd1;

	// Shadow copy of the supervisor's registers and state.
	logic [CFG_W-1:0]   first_wd_ms, wd_period_ms, off_delay_ms;
	host_state_t        host_now;
	logic               off_pending, wd_answered;
	logic [TIMER_W-1:0] wdog_cnt, dly_cnt;

	result_t expected_q[$];
	int      mismatch_cnt;

	// A timer load saturates at the largest value the timer holds.
	function automatic logic [TIMER_W-1:0] timer_load(input logic [CFG_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		if (w > TIMER_MAX)
			w = TIMER_MAX;
		return w[TIMER_W-1:0];
	endfunction

	// Timers count down by the elapsed time and stop at zero.
	function automatic logic [TIMER_W-1:0] count_down(input logic [TIMER_W-1:0] t,
			input logic [ELAPSED_W-1:0] el);
		logic [63:0] d;
		d = 64'(el);
		if (64'(t) > d)
			return t - TIMER_W'(el);
		return '0;
	endfunction

	// One handler call: advances the shadow state and returns the expected result.
	task automatic host_call(input item_t c, output result_t r);
		host_state_t st;
		r = '0;
		st = host_now;
		wdog_cnt = count_down(wdog_cnt, c.elapsed);
		dly_cnt = count_down(dly_cnt, c.elapsed);
		case (st)
			ST_UNKNOWN: begin
				if (c.rx) begin
					wdog_cnt = timer_load(first_wd_ms);
					r.query = 1'b1;
					wd_answered = 1'b0;
					st = ST_RUN;
				end else begin
					st = ST_STBY;
				end
			end
			ST_RUN: begin
				// Watchdog expiry: query again if the last query was answered, else shut down.
				if (wdog_cnt == '0) begin
					if (wd_answered) begin
						r.query = 1'b1;
						wdog_cnt = timer_load(wd_period_ms);
						wd_answered = 1'b0;
					end else begin
						st = ST_SHUT;
					end
				end
				r.led_mode = (c.key == KEY_PRESSING) ? LED_BLINK_1000 : LED_ON;
				if (c.key == KEY_SUPER_LONG)
					off_pending = 1'b1;
				case (c.msg)
					MSG_STATUS:    r.resp = RESP_STATUS;
					MSG_ANALOG:    r.resp = RESP_ANALOG;
					MSG_POWEROFF: begin
						r.resp = RESP_POWEROFF;
						off_pending = 1'b1;
						st = ST_SHUT;
					end
					MSG_VERSION:   r.resp = RESP_VERSION;
					MSG_BOOT:      r.boot = 1'b1;
					MSG_SHUT_ACK:  st = ST_SHUT;
					MSG_READY_ACK: wd_answered = 1'b1;
					default: ;
				endcase
			end
			ST_SHUT: begin
				r.led_mode = LED_BLINK_250;
				if (!c.rx)
					st = ST_STBY;
			end
			ST_STBY: begin
				r.led_mode = LED_OFF;
				if (c.rx) begin
					st = ST_START;
				end else begin
					if (off_pending) begin
						dly_cnt = timer_load(off_delay_ms);
						st = ST_PWROFF;
					end
					// The power-cycle wait uses up the delay timer.
					if (c.key == KEY_SHORT) begin
						r.supply = SUP_CYCLE;
						dly_cnt = '0;
					end
				end
			end
			ST_START: begin
				r.led_mode = LED_BLINK_150;
				if (c.rx && dly_cnt == '0 && c.msg != MSG_NONE) begin
					wd_answered = 1'b1;
					st = ST_RUN;
				end
			end
			ST_PWROFF: begin
				if (dly_cnt == '0) begin
					r.supply = SUP_OFF;
					off_pending = 1'b0;
					st = ST_STBY;
				end
			end
			default: ;
		endcase
		host_now = st;
		r.host_state = st;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Watch both channels and the register port at every clock edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		item_t   call;
		result_t want;
		if (!arst_n) begin
			first_wd_ms = RST_FIRST_WD;
			wd_period_ms = RST_WD_PERIOD;
			off_delay_ms = RST_OFF_DELAY;
			host_now = ST_UNKNOWN;
			off_pending = 1'b0;
			wd_answered = 1'b0;
			wdog_cnt = '0;
			dly_cnt = '0;
			expected_q.delete();
			mismatch_cnt = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			// A result transaction is matched against the oldest expectation.
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatch_cnt++;
				end else begin
					want = expected_q.pop_front();
					check_field("host_state", int'(want.host_state), int'(host_state));
					check_field("led_mode", int'(want.led_mode), int'(led_mode));
					check_field("send_ready_query", int'(want.query), int'(send_ready_query));
					check_field("response_kind", int'(want.resp), int'(response_kind));
					check_field("supply_action", int'(want.supply), int'(supply_action));
					check_field("enter_bootloader", int'(want.boot), int'(enter_bootloader));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_WD:  first_wd_ms = cfg_wdata;
					CFG_WD_PERIOD: wd_period_ms = cfg_wdata;
					CFG_OFF_DELAY: off_delay_ms = cfg_wdata;
					default: ;
				endcase
			end
			// Each accepted call transaction queues exactly one expected result.
			if (item_valid && item_ready) begin
				call.elapsed = elapsed_ms;
				call.key = key_event;
				call.rx = rx_level;
				call.msg = rx_message;
				host_call(call, want);
				expected_q.push_back(want);
			end
			errors <= mismatch_cnt;
			outstanding <= expected_q.size();
		end
	end

endmodule

// File: sim/host_power_supervisor_unit_tb.sv
// Testbench top of the host power supervisor: clock, reset, call stimulus and verdict.
module host_power_supervisor_unit_tb;
	import hps_pkg::*;

	localparam int TIMER_W     = 16;
	localparam int PHASE_CALLS = 188;
	localparam int QUIET_LIMIT = 1000;

	// Codes the package does not name.
	localparam logic [KEY_W-1:0] KEY_NONE     = 3'd0;
	localparam logic [KEY_W-1:0] KEY_DOUBLE   = 3'd3;
	localparam logic [KEY_W-1:0] KEY_LONG     = 3'd4;
	localparam logic [KEY_W-1:0] KEY_UNDEF_LO = 3'd6;
	localparam logic [KEY_W-1:0] KEY_UNDEF_HI = 3'd7;
	localparam logic [MSG_W-1:0] MSG_OTHER    = 4'd8;
	localparam logic [MSG_W-1:0] MSG_UNDEF_HI = 4'd15;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic [ELAPSED_W-1:0] elapsed_ms = '0;
	logic [KEY_W-1:0]     key_event = '0;
	logic                 rx_level = 1'b0;
	logic [MSG_W-1:0]     rx_message = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [2:0]           host_state;
	logic [LED_W-1:0]     led_mode;
	logic                 send_ready_query;
	logic [RESP_W-1:0]    response_kind;
	logic [SUP_W-1:0]     supply_action;
	logic                 enter_bootloader;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	int check_errors;
	int pending_calls;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	host_power_supervisor_unit #(.TIMER_WIDTH(TIMER_W)) uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.elapsed_ms(elapsed_ms), .key_event(key_event),
		.rx_level(rx_level), .rx_message(rx_message),
		.result_valid(result_valid), .result_ready(result_ready),
		.host_state(host_state), .led_mode(led_mode),
		.send_ready_query(send_ready_query), .response_kind(response_kind),
		.supply_action(supply_action), .enter_bootloader(enter_bootloader),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	hps_call_checker #(.TIMER_W(TIMER_W)) u_check (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.elapsed_ms(elapsed_ms), .key_event(key_event),
		.rx_level(rx_level), .rx_message(rx_message),
		.result_valid(result_valid), .result_ready(result_ready),
		.host_state(host_state), .led_mode(led_mode),
		.send_ready_query(send_ready_query), .response_kind(response_kind),
		.supply_action(supply_action), .enter_bootloader(enter_bootloader),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(check_errors), .outstanding(pending_calls)
	);

	// The result side stalls at random with the current stall rate.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// End the run if no transaction is accepted for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("host_power_supervisor_unit_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one call after an optional idle gap and hold it until it is accepted.
	task automatic put_call(input logic [ELAPSED_W-1:0] el, input logic [KEY_W-1:0] key,
			input logic rx, input logic [MSG_W-1:0] msg);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		elapsed_ms <= el;
		key_event <= key;
		rx_level <= rx;
		rx_message <= msg;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// Stop offering calls and wait until every expected result has come back.
	task automatic drain_calls();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_calls != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write all three registers on consecutive cycles while the block is idle.
	task automatic set_regs(input logic [CFG_W-1:0] first_wd, input logic [CFG_W-1:0] period,
			input logic [CFG_W-1:0] off_delay);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_WD;
		cfg_wdata <= first_wd;
		@(posedge clk);
		cfg_index <= CFG_WD_PERIOD;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_index <= CFG_OFF_DELAY;
		cfg_wdata <= off_delay;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Host sessions: the line level holds for a stretch of calls, with the odd glitch.
	// Messages are mostly ready acks and ordinary requests, seldom a shutdown.
	task automatic random_calls(input int n);
		logic                 rx_now;
		logic                 rx;
		int                   hold;
		int                   roll;
		logic [ELAPSED_W-1:0] el;
		logic [KEY_W-1:0]     key;
		logic [MSG_W-1:0]     msg;
		rx_now = 1'b1;
		hold = 0;
		repeat (n) begin
			if (hold == 0) begin
				hold = $urandom_range(40, 3);
				if ($urandom_range(99) < 80)
					rx_now = ~rx_now;
			end
			hold--;
			rx = ($urandom_range(99) < 5) ? ~rx_now : rx_now;
			roll = $urandom_range(99);
			if (roll < 55)
				el = ELAPSED_W'($urandom_range(40));
			else if (roll < 85)
				el = ELAPSED_W'($urandom_range(255));
			else
				el = ELAPSED_W'($urandom_range(1023));
			key = ($urandom_range(99) < 80) ? KEY_NONE : KEY_W'($urandom_range(7));
			roll = $urandom_range(99);
			if (roll < 35) begin
				msg = MSG_READY_ACK;
			end else if (roll < 55) begin
				msg = MSG_NONE;
			end else if (roll < 78) begin
				case ($urandom_range(4))
					0: msg = MSG_STATUS;
					1: msg = MSG_ANALOG;
					2: msg = MSG_VERSION;
					3: msg = MSG_BOOT;
					default: msg = MSG_OTHER;
				endcase
			end else if (roll < 82) begin
				msg = ($urandom_range(1) != 0) ? MSG_SHUT_ACK : MSG_POWEROFF;
			end else begin
				msg = MSG_W'($urandom_range(15));
			end
			put_call(el, key, rx, msg);
		end
	endtask

	initial begin : stimulus
		int ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short timers so the directed walk sees every timeout.
		set_regs(16'd300, 16'd200, 16'd150);

		// Host found running, then each ordinary request and several keys while running.
		put_call(10'd0, KEY_NONE, 1'b1, MSG_NONE);
		put_call(10'd5, KEY_PRESSING, 1'b1, MSG_STATUS);
		put_call(10'd5, KEY_UNDEF_LO, 1'b1, MSG_ANALOG);
		put_call(10'd5, KEY_UNDEF_HI, 1'b1, MSG_VERSION);
		put_call(10'd5, KEY_NONE, 1'b1, MSG_BOOT);
		put_call(10'd5, KEY_NONE, 1'b1, MSG_OTHER);
		put_call(10'd5, KEY_NONE, 1'b1, MSG_UNDEF_HI);
		put_call(10'd5, KEY_NONE, 1'b1, MSG_READY_ACK);
		// Answered watchdog expiry reloads; unanswered expiry shuts the host down.
		put_call(10'd1023, KEY_DOUBLE, 1'b1, MSG_NONE);
		put_call(10'd200, KEY_LONG, 1'b1, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b0, MSG_NONE);
		// Power-cycle from standby, then a restart that waits for a message.
		put_call(10'd1, KEY_SHORT, 1'b0, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_STATUS);
		// Super long press arms power-off; shutdown ack, standby, delayed supply off.
		put_call(10'd1, KEY_SUPER_LONG, 1'b1, MSG_READY_ACK);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_SHUT_ACK);
		put_call(10'd1, KEY_NONE, 1'b0, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b0, MSG_NONE);
		put_call(10'd100, KEY_NONE, 1'b0, MSG_NONE);
		put_call(10'd100, KEY_NONE, 1'b0, MSG_NONE);
		// Power-off request, then a short press in standby with power-off pending.
		put_call(10'd1, KEY_NONE, 1'b1, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_STATUS);
		put_call(10'd1, KEY_NONE, 1'b1, MSG_POWEROFF);
		put_call(10'd1, KEY_NONE, 1'b0, MSG_NONE);
		put_call(10'd1, KEY_SHORT, 1'b0, MSG_NONE);
		put_call(10'd1, KEY_NONE, 1'b0, MSG_NONE);

		// Random sessions under several register settings and idle patterns.
		for (ph = 0; ph < 6; ph++) begin
			drain_calls();
			case (ph)
				0: set_regs(16'd0, 16'd0, 16'd0);
				1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_regs(CFG_W'($urandom_range(600)), CFG_W'($urandom_range(600)),
						CFG_W'($urandom_range(600)));
				3: set_regs(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
						CFG_W'($urandom_range(65535)));
				4: set_regs(RST_FIRST_WD, RST_WD_PERIOD, RST_OFF_DELAY);
				default: set_regs(CFG_W'($urandom_range(1500)), CFG_W'($urandom_range(800)),
						CFG_W'($urandom_range(1500)));
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 45;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 45;
				end
				default: begin
					send_idle_pct = 26;
					recv_stall_pct <= 26;
				end
			endcase
			random_calls(PHASE_CALLS);
		end
		drain_calls();

		if (check_errors == 0)
			$display("host_power_supervisor_unit_tb: done, clean");
		else
			$display("host_power_supervisor_unit_tb: done, errors");
		$finish;
	end

endmodule
